// ----- sv/zxr_pkg.sv -----
// Shared types, constants and address helpers for the screen renderer.
// No dependencies; every other file except zxr_ram takes names from here by scope.
package zxr_pkg;

	localparam int unsigned SCR_BYTES    = 6912;
	localparam int unsigned BITMAP_BYTES = 6144;
	localparam int unsigned SCR_ROWS     = 192;
	localparam int unsigned ADDR_W       = 13;

	localparam logic [7:0] LEVEL_NORMAL = 8'd170;
	localparam logic [7:0] LEVEL_BRIGHT = 8'd255;

	localparam logic CMD_STORE  = 1'b0;
	localparam logic CMD_RENDER = 1'b1;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] byte_address;
		logic [7:0]        byte_value;
		logic [7:0]        pixel_row;
		logic [4:0]        char_column;
	} zxr_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic       last_of_run;
	} zxr_out_t;

	// One render job waiting for the pixel stage.
	typedef struct packed {
		logic [7:0] bits;
		logic [7:0] attr;
		logic [7:0] row;
		logic [4:0] col;
	} zxr_entry_t;

	// Screen memory access issued by the front end.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr_bits;
		logic [ADDR_W-1:0] raddr_attr;
	} zxr_ram_req_t;

	// Interleaved bitmap address of pixel row y, character column col.
	function automatic logic [ADDR_W-1:0] bitmap_addr(input logic [7:0] y,
			input logic [4:0] col);
		bitmap_addr = {y[7:6], y[2:0], y[5:3], col};
	endfunction

	// Attribute address of the 8x8 cell holding row y, column col.
	function automatic logic [ADDR_W-1:0] attr_addr(input logic [7:0] y,
			input logic [4:0] col);
		attr_addr = ADDR_W'(BITMAP_BYTES) + ADDR_W'({y[7:3], col});
	endfunction

endpackage

// ----- sv/zxr_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module zxr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ----- sv/zxr_front.sv -----
// Front end: accepts commands, writes stores, issues screen reads for renders
// and pushes finished lookups into the job queue. Depends on zxr_pkg.
module zxr_front #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  zxr_pkg::zxr_in_t                   item,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
	output zxr_pkg::zxr_ram_req_t              ram_req,
	input  logic [7:0]                         bits_rd,
	input  logic [7:0]                         attr_rd,
	output logic                               push,
	output zxr_pkg::zxr_entry_t                push_entry
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic       accept;
	logic       render_ok;
	logic       valid_s1;
	logic [7:0] row_s1;
	logic [4:0] col_s1;
	logic [CW:0] pending;

	// Count the lookup in flight against the queue's free room.
	assign pending = {1'b0, q_count} + (CW+1)'(valid_s1);
	assign busy    = pending >= (CW+1)'(QUEUE_DEPTH);
	assign accept  = start && !busy;

	assign render_ok = accept && (item.command == zxr_pkg::CMD_RENDER) &&
		(item.pixel_row < 8'(zxr_pkg::SCR_ROWS));

	always_comb begin
		ram_req.we = accept && (item.command == zxr_pkg::CMD_STORE) &&
			(item.byte_address < zxr_pkg::ADDR_W'(zxr_pkg::SCR_BYTES));
		ram_req.waddr      = item.byte_address;
		ram_req.wdata      = item.byte_value;
		ram_req.raddr_bits = zxr_pkg::bitmap_addr(item.pixel_row, item.char_column);
		ram_req.raddr_attr = zxr_pkg::attr_addr(item.pixel_row, item.char_column);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= render_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (render_ok) begin
			row_s1 <= item.pixel_row;
			col_s1 <= item.char_column;
		end
	end

	assign push            = valid_s1;
	assign push_entry.bits = bits_rd;
	assign push_entry.attr = attr_rd;
	assign push_entry.row  = row_s1;
	assign push_entry.col  = col_s1;

endmodule

// ----- sv/zxr_queue.sv -----
// Small job queue between front end and pixel stage.
// Depends on zxr_pkg for the entry type.
module zxr_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  zxr_pkg::zxr_entry_t            push_entry,
	input  logic                           pop,
	output logic                           head_valid,
	output zxr_pkg::zxr_entry_t            head,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	zxr_pkg::zxr_entry_t ent_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;
	logic                do_pop;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign do_pop     = pop && (count_q != '0);
	assign head_valid = count_q != '0;
	assign head       = ent_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ----- sv/zxr_back.sv -----
// Pixel stage: takes one job from the queue and emits its eight pixels,
// one per clock, through an output register. Depends on zxr_pkg.
module zxr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  zxr_pkg::zxr_entry_t  head,
	output logic                 pop,
	output logic                 strobe,
	output zxr_pkg::zxr_out_t    result
);

	logic                act_q;
	logic [2:0]          idx_q;
	zxr_pkg::zxr_entry_t ent_q;
	logic                strobe_q;
	zxr_pkg::zxr_out_t   res_q;
	zxr_pkg::zxr_out_t   pix;
	logic                at_end;

	logic       set;
	logic [2:0] colour;
	logic [7:0] level;

	assign at_end = act_q && (idx_q == 3'd7);
	assign pop    = head_valid && (!act_q || at_end);

	always_comb begin
		set    = ent_q.bits[3'd7 - idx_q];
		colour = set ? ent_q.attr[2:0] : ent_q.attr[5:3];
		level  = ent_q.attr[6] ? zxr_pkg::LEVEL_BRIGHT : zxr_pkg::LEVEL_NORMAL;
		pix.red         = colour[1] ? level : 8'd0;
		pix.green       = colour[2] ? level : 8'd0;
		pix.blue        = colour[0] ? level : 8'd0;
		pix.pixel_x     = {ent_q.col, idx_q};
		pix.pixel_y     = ent_q.row;
		pix.last_of_run = idx_q == 3'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
			if (pop) begin
				act_q <= 1'b1;
				idx_q <= '0;
			end else if (at_end) begin
				act_q <= 1'b0;
			end else if (act_q) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
		if (act_q) begin
			res_q <= pix;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

// ----- sv/zx_screen_to_rgb_renderer.sv -----
// Top level of the screen renderer: front end, screen RAM, job queue, pixel stage.
// Depends on zxr_pkg, zxr_ram, zxr_front, zxr_queue and zxr_back.
//
// The block holds a 6912-byte screen image (6144 bitmap bytes in the interleaved
// layout, then 768 attribute bytes) in a RAM with one write port and two read
// ports; the RAM has no reset and no clearing pass, so render only what you
// stored. A command is taken when start is high and busy is low. A store
// writes at once; addresses of 6912 and up are dropped. A render of a row
// below 192 reads bitmap and attribute bytes in the accept cycle, is pushed
// into a job queue of QUEUE_DEPTH entries in the next cycle, and the pixel
// stage emits its eight pixels, leftmost first, one per clock, each marked
// by one cycle of strobe; the first pixel passes through the RAM read
// register, the queue, and the pixel stage's job and output registers. Rows
// of 192 and up give nothing. The pixel stage's one pixel per clock, eight
// per render, sets the sustained rate; stores and renders are taken back to
// back while it works, and busy rises only when the queue and the lookup in
// flight hold QUEUE_DEPTH jobs. Results cannot be held off: sample every beat.
module zx_screen_to_rgb_renderer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  zxr_pkg::zxr_in_t  item,
	output logic              strobe,
	output zxr_pkg::zxr_out_t result
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	zxr_pkg::zxr_ram_req_t ram_req;
	logic [7:0]            bits_rd;
	logic [7:0]            attr_rd;
	logic                  push;
	zxr_pkg::zxr_entry_t   push_entry;
	logic                  pop;
	logic                  head_valid;
	zxr_pkg::zxr_entry_t   head;
	logic [CW-1:0]         q_count;

	// Accept commands, write stores, start lookups for renders.
	zxr_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.q_count   (q_count),
		.ram_req   (ram_req),
		.bits_rd   (bits_rd),
		.attr_rd   (attr_rd),
		.push      (push),
		.push_entry(push_entry)
	);

	// Screen image: bitmap byte on port a, attribute byte on port b.
	zxr_ram #(
		.WIDTH(8),
		.DEPTH(zxr_pkg::SCR_BYTES)
	) u_screen (
		.clk    (clk),
		.we     (ram_req.we),
		.waddr  (ram_req.waddr),
		.wdata  (ram_req.wdata),
		.raddr_a(ram_req.raddr_bits),
		.raddr_b(ram_req.raddr_attr),
		.rdata_a(bits_rd),
		.rdata_b(attr_rd)
	);

	// Hold looked-up jobs until the pixel stage is free.
	zxr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head),
		.count     (q_count)
	);

	// Emit eight pixels per job, one beat per clock.
	zxr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.strobe    (strobe),
		.result    (result)
	);

	// A push never lands on a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < CW'(QUEUE_DEPTH)) || pop)
		else $error("job queue overflow");

	// A run of eight beats is never broken once it starts.
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last_of_run) |=> strobe)
		else $error("pixel run broken");

	// The last beat of a run is the rightmost pixel of its byte.
	a_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last_of_run) |-> (result.pixel_x[2:0] == 3'd7))
		else $error("last beat at wrong position");

	// Stores outside the image never reach the RAM.
	a_store_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (ram_req.waddr < zxr_pkg::ADDR_W'(zxr_pkg::SCR_BYTES)))
		else $error("store beyond screen image");

endmodule
